FILE: hw/rtl/mlrls_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the minimum-latency route local search block.
// No dependencies; imported by mlrls_ctrl, mlrls_dp and the top level.
package mlrls_pkg;

  localparam int MAX_NODES = 64;
  localparam int NPOS      = MAX_NODES + 1;
  localparam int NODE_W    = 6;
  localparam int POS_W     = 7;
  localparam int DIST_W    = 16;
  localparam int T_W       = 24;   // route duration, max 64 * 65535
  localparam int C_W       = 32;   // route latency
  localparam int W_W       = 7;    // segment weight, up to 64
  localparam int DADDR_W   = 2 * NODE_W;

  localparam logic [2:0] REQ_LD_DIST  = 3'd0;
  localparam logic [2:0] REQ_LD_ROUTE = 3'd1;
  localparam logic [2:0] REQ_SWAP     = 3'd2;
  localparam logic [2:0] REQ_REVERSE  = 3'd3;
  localparam logic [2:0] REQ_READ     = 3'd4;

  // first join operand
  localparam logic [2:0] OP1_ZERO   = 3'd0;
  localparam logic [2:0] OP1_SINGLE = 3'd1;
  localparam logic [2:0] OP1_P      = 3'd2;
  localparam logic [2:0] OP1_M      = 3'd3;
  localparam logic [2:0] OP1_A      = 3'd4;

  // second join operand
  localparam logic [2:0] OP2_SINGLE = 3'd0;
  localparam logic [2:0] OP2_SREG   = 3'd1;
  localparam logic [2:0] OP2_M      = 3'd2;
  localparam logic [2:0] OP2_R      = 3'd3;
  localparam logic [2:0] OP2_SMEM   = 3'd4;

  // join destination
  localparam logic [2:0] DST_SREG = 3'd0;
  localparam logic [2:0] DST_P    = 3'd1;
  localparam logic [2:0] DST_M    = 3'd2;
  localparam logic [2:0] DST_R    = 3'd3;
  localparam logic [2:0] DST_A    = 3'd4;

  typedef struct packed {
    logic [T_W-1:0] t;
    logic [C_W-1:0] c;
    logic [W_W-1:0] w;
  } seg_t;

  typedef struct packed {
    logic             ld_dist;
    logic             ld_route;
    logic             rd_en;
    logic [POS_W-1:0] rd_a;
    logic [POS_W-1:0] rd_b;
    logic             s_rd_en;
    logic [POS_W-1:0] s_rd_addr;
    logic             join_en;
    logic [2:0]       op1;
    logic [2:0]       op2;
    logic [2:0]       dest;
    logic             w_single;
    logic             zero_d;
    logic             s_wr_en;
    logic [POS_W-1:0] s_wr_addr;
    logic             take_old;
    logic             pass_init;
    logic             cmp_en;
    logic [POS_W-1:0] cur_i;
    logic [POS_W-1:0] cur_j;
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
    logic             wr_sel_b;
    logic             out_load;
    logic             out_read;
    logic             read_oob;
  } cmd_t;

  typedef struct packed {
    logic             better;
    logic [POS_W-1:0] bi;
    logic [POS_W-1:0] bj;
  } sts_t;

endpackage

FILE: hw/rtl/mlrls_dp.sv
`timescale 1ns / 1ps
// Datapath: distance, route and suffix memories, segment join unit, best-move tracking.
// Depends on mlrls_pkg; driven by commands from mlrls_ctrl.
module mlrls_dp (
  input  logic                          clk_i,
  input  mlrls_pkg::cmd_t               cmd_i,
  output mlrls_pkg::sts_t               sts_o,
  input  logic [mlrls_pkg::NODE_W-1:0]  from_node_i,
  input  logic [mlrls_pkg::NODE_W-1:0]  to_node_i,
  input  logic [mlrls_pkg::DIST_W-1:0]  distance_i,
  input  logic [mlrls_pkg::POS_W-1:0]   position_i,
  input  logic [mlrls_pkg::NODE_W-1:0]  node_i,
  output logic                          applied_o,
  output logic [mlrls_pkg::POS_W-1:0]   move_i_o,
  output logic [mlrls_pkg::POS_W-1:0]   move_j_o,
  output logic [mlrls_pkg::C_W-1:0]     old_latency_o,
  output logic [mlrls_pkg::C_W-1:0]     found_latency_o,
  output logic [mlrls_pkg::NODE_W-1:0]  read_node_o
);
  import mlrls_pkg::*;

  logic [DIST_W-1:0] dist_mem [1 << DADDR_W];
  logic [NODE_W-1:0] route_mem [NPOS];
  seg_t              smem [NPOS];

  logic [NODE_W-1:0] rq_a_q, rq_b_q;
  logic [DIST_W-1:0] dist_q;
  seg_t              sq_q, sreg_q, p_q, m_q, r_q, a_q;
  logic [C_W-1:0]    best_q, old_q;
  logic [POS_W-1:0]  bi_q, bj_q;

  logic              r_we;
  logic [POS_W-1:0]  r_wa;
  logic [NODE_W-1:0] r_wd;

  seg_t                 op1, op2, single, res;
  logic [DIST_W-1:0]    d;
  logic [T_W-1:0]       lead;
  logic [W_W+T_W-1:0]   prod;
  logic [C_W+1:0]       csum;

  // route memory: one write port, two registered read ports
  always_comb begin
    r_we = (cmd_i.ld_route && (position_i <= POS_W'(MAX_NODES))) || cmd_i.wr_en;
    r_wa = cmd_i.ld_route ? position_i : cmd_i.wr_addr;
    r_wd = cmd_i.ld_route ? node_i : (cmd_i.wr_sel_b ? rq_b_q : rq_a_q);
  end

  always_ff @(posedge clk_i) begin
    if (r_we) begin
      route_mem[r_wa] <= r_wd;
    end
    if (cmd_i.rd_en) begin
      rq_a_q <= route_mem[cmd_i.rd_a];
      rq_b_q <= route_mem[cmd_i.rd_b];
    end
  end

  // distance memory: the edge lookup follows the route read in the next cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_dist) begin
      dist_mem[{from_node_i, to_node_i}] <= distance_i;
    end
    dist_q <= dist_mem[{rq_a_q, rq_b_q}];
  end

  // join: t = t1+d+t2, c = c1 + w2*(t1+d) + c2, w = w1+w2
  always_comb begin
    single = '{t: '0, c: '0, w: W_W'(cmd_i.w_single)};
    case (cmd_i.op1)
      OP1_ZERO:   op1 = '0;
      OP1_SINGLE: op1 = single;
      OP1_P:      op1 = p_q;
      OP1_M:      op1 = m_q;
      OP1_A:      op1 = a_q;
      default:    op1 = '0;
    endcase
    case (cmd_i.op2)
      OP2_SINGLE: op2 = single;
      OP2_SREG:   op2 = sreg_q;
      OP2_M:      op2 = m_q;
      OP2_R:      op2 = r_q;
      OP2_SMEM:   op2 = sq_q;
      default:    op2 = '0;
    endcase
    d     = cmd_i.zero_d ? '0 : dist_q;
    lead  = op1.t + T_W'(d);
    prod  = (W_W+T_W)'(op2.w) * (W_W+T_W)'(lead);
    // latency saturates at all ones
    csum  = (C_W+2)'(op1.c) + (C_W+2)'(prod) + (C_W+2)'(op2.c);
    res.c = (csum[C_W+1:C_W] != 2'b00) ? '1 : csum[C_W-1:0];
    res.t = lead + op2.t;
    res.w = op1.w + op2.w;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.s_rd_en) begin
      sq_q <= smem[cmd_i.s_rd_addr];
    end
    if (cmd_i.s_wr_en) begin
      smem[cmd_i.s_wr_addr] <= res;
    end
    if (cmd_i.join_en) begin
      case (cmd_i.dest)
        DST_SREG: sreg_q <= res;
        DST_P:    p_q    <= res;
        DST_M:    m_q    <= res;
        DST_R:    r_q    <= res;
        DST_A:    a_q    <= res;
        default:  a_q    <= res;
      endcase
    end
    if (cmd_i.take_old) begin
      old_q <= res.c;
    end
    if (cmd_i.pass_init) begin
      best_q <= '1;
      bi_q   <= '0;
      bj_q   <= '0;
    end else if (cmd_i.cmp_en && (a_q.c < best_q)) begin
      best_q <= a_q.c;
      bi_q   <= cmd_i.cur_i;
      bj_q   <= cmd_i.cur_j;
    end
  end

  assign sts_o = '{better: (best_q < old_q), bi: bi_q, bj: bj_q};

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_read) begin
        applied_o       <= 1'b0;
        move_i_o        <= '0;
        move_j_o        <= '0;
        old_latency_o   <= '0;
        found_latency_o <= '0;
        read_node_o     <= cmd_i.read_oob ? '0 : rq_a_q;
      end else begin
        applied_o       <= (best_q < old_q);
        move_i_o        <= bi_q;
        move_j_o        <= bj_q;
        old_latency_o   <= old_q;
        found_latency_o <= best_q;
        read_node_o     <= '0;
      end
    end
  end

endmodule

FILE: hw/rtl/mlrls_ctrl.sv
`timescale 1ns / 1ps
// Controller: request decode, pass sequencing (suffix build, move scan, apply), handshakes.
// Depends on mlrls_pkg; commands mlrls_dp.
module mlrls_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   req_type_i,
  input  logic [mlrls_pkg::POS_W-1:0]  position_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  input  logic                         cfg_we_i,
  input  logic [mlrls_pkg::POS_W-1:0]  cfg_wdata_i,
  output mlrls_pkg::cmd_t              cmd_o,
  input  mlrls_pkg::sts_t              sts_i
);
  import mlrls_pkg::*;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SI   = 5'd1;   // suffix seed at last position
  localparam logic [4:0] ST_SS   = 5'd2;   // suffix step k
  localparam logic [4:0] ST_PI   = 5'd3;   // prefix seed
  localparam logic [4:0] ST_PU   = 5'd4;   // prefix grow
  localparam logic [4:0] ST_MI   = 5'd5;   // swap interior seed
  localparam logic [4:0] ST_MU   = 5'd6;   // swap interior grow
  localparam logic [4:0] ST_C1   = 5'd7;
  localparam logic [4:0] ST_C2   = 5'd8;
  localparam logic [4:0] ST_C3   = 5'd9;
  localparam logic [4:0] ST_C4   = 5'd10;
  localparam logic [4:0] ST_RI   = 5'd11;  // reversed segment seed
  localparam logic [4:0] ST_RU   = 5'd12;  // reversed segment grow
  localparam logic [4:0] ST_V1   = 5'd13;
  localparam logic [4:0] ST_V2   = 5'd14;
  localparam logic [4:0] ST_CMP  = 5'd15;
  localparam logic [4:0] ST_AP   = 5'd16;
  localparam logic [4:0] ST_A0   = 5'd17;
  localparam logic [4:0] ST_A1   = 5'd18;
  localparam logic [4:0] ST_A2   = 5'd19;
  localparam logic [4:0] ST_A3   = 5'd20;
  localparam logic [4:0] ST_RD   = 5'd21;
  localparam logic [4:0] ST_OUT  = 5'd22;

  logic [4:0]       state_q, state_d;
  logic [1:0]       ph_q, ph_d;
  logic [POS_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d, pos_q, pos_d;
  logic [POS_W-1:0] ncnt_q, last;
  logic             swap_q, swap_d, rdk_q, rdk_d;
  logic             out_valid_q, out_valid_d;
  logic             jstep, need_rd, need_srd, fin;
  cmd_t             cmd;

  always_comb begin
    if (ncnt_q < POS_W'(4)) begin
      last = POS_W'(4);
    end else if (ncnt_q > POS_W'(MAX_NODES)) begin
      last = POS_W'(MAX_NODES);
    end else begin
      last = ncnt_q;
    end
  end

  always_comb begin
    cmd      = '0;
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    pos_d    = pos_q;
    swap_d   = swap_q;
    rdk_d    = rdk_q;
    jstep    = 1'b0;
    need_rd  = 1'b0;
    need_srd = 1'b0;
    fin      = (ph_q == 2'd2);
    in_ready_o = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (req_type_i)
            REQ_LD_DIST:  cmd.ld_dist = 1'b1;
            REQ_LD_ROUTE: cmd.ld_route = 1'b1;
            REQ_SWAP, REQ_REVERSE: begin
              cmd.pass_init = 1'b1;
              swap_d  = (req_type_i == REQ_SWAP);
              rdk_d   = 1'b0;
              state_d = ST_SI;
            end
            REQ_READ: begin
              pos_d   = position_i;
              rdk_d   = 1'b1;
              state_d = ST_RD;
            end
            default: ;
          endcase
        end
      end
      ST_SI: begin
        jstep = 1'b1;
        cmd.op1 = OP1_ZERO; cmd.op2 = OP2_SINGLE; cmd.zero_d = 1'b1;
        cmd.dest = DST_SREG; cmd.s_wr_addr = last;
        if (fin) begin
          k_d = last - 7'd1;
          state_d = ST_SS;
        end
      end
      ST_SS: begin
        jstep = 1'b1; need_rd = 1'b1;
        cmd.rd_a = k_q; cmd.rd_b = k_q + 7'd1;
        cmd.op1 = OP1_SINGLE; cmd.op2 = OP2_SREG; cmd.w_single = (k_q != '0);
        cmd.dest = DST_SREG; cmd.s_wr_addr = k_q;
        if (fin) begin
          cmd.take_old = (k_q == '0);
          if (k_q == '0) begin
            state_d = ST_PI;
          end else begin
            k_d = k_q - 7'd1;
          end
        end
      end
      ST_PI: begin
        jstep = 1'b1;
        cmd.op1 = OP1_ZERO; cmd.op2 = OP2_SINGLE; cmd.zero_d = 1'b1; cmd.dest = DST_P;
        if (fin) begin
          i_d = 7'd1;
          j_d = swap_q ? 7'd3 : 7'd2;
          state_d = swap_q ? ST_MI : ST_RI;
        end
      end
      ST_PU: begin
        jstep = 1'b1; need_rd = 1'b1;
        cmd.rd_a = i_q - 7'd1; cmd.rd_b = i_q;
        cmd.op1 = OP1_P; cmd.op2 = OP2_SINGLE; cmd.w_single = 1'b1; cmd.dest = DST_P;
        if (fin) begin
          i_d = i_q + 7'd1;
          j_d = swap_q ? i_q + 7'd3 : i_q + 7'd2;
          if (i_q + 7'd3 < last) begin
            state_d = swap_q ? ST_MI : ST_RI;
          end else begin
            state_d = ST_AP;
          end
        end
      end
      ST_MI: begin
        jstep = 1'b1;
        cmd.op1 = OP1_ZERO; cmd.op2 = OP2_SINGLE; cmd.zero_d = 1'b1;
        cmd.w_single = 1'b1; cmd.dest = DST_M;
        if (fin) state_d = ST_C1;
      end
      ST_MU: begin
        jstep = 1'b1; need_rd = 1'b1;
        cmd.rd_a = j_q - 7'd2; cmd.rd_b = j_q - 7'd1;
        cmd.op1 = OP1_M; cmd.op2 = OP2_SINGLE; cmd.w_single = 1'b1; cmd.dest = DST_M;
        if (fin) state_d = ST_C1;
      end
      ST_C1: begin
        jstep = 1'b1; need_rd = 1'b1;
        cmd.rd_a = i_q - 7'd1; cmd.rd_b = j_q;
        cmd.op1 = OP1_P; cmd.op2 = OP2_SINGLE; cmd.w_single = 1'b1; cmd.dest = DST_A;
        if (fin) state_d = ST_C2;
      end
      ST_C2: begin
        jstep = 1'b1; need_rd = 1'b1;
        cmd.rd_a = j_q; cmd.rd_b = i_q + 7'd1;
        cmd.op1 = OP1_A; cmd.op2 = OP2_M; cmd.dest = DST_A;
        if (fin) state_d = ST_C3;
      end
      ST_C3: begin
        jstep = 1'b1; need_rd = 1'b1;
        cmd.rd_a = j_q - 7'd1; cmd.rd_b = i_q;
        cmd.op1 = OP1_A; cmd.op2 = OP2_SINGLE; cmd.w_single = 1'b1; cmd.dest = DST_A;
        if (fin) state_d = ST_C4;
      end
      ST_C4: begin
        jstep = 1'b1; need_rd = 1'b1; need_srd = 1'b1;
        cmd.rd_a = i_q; cmd.rd_b = j_q + 7'd1; cmd.s_rd_addr = j_q + 7'd1;
        cmd.op1 = OP1_A; cmd.op2 = OP2_SMEM; cmd.dest = DST_A;
        if (fin) state_d = ST_CMP;
      end
      ST_RI: begin
        jstep = 1'b1;
        cmd.op1 = OP1_ZERO; cmd.op2 = OP2_SINGLE; cmd.zero_d = 1'b1;
        cmd.w_single = 1'b1; cmd.dest = DST_R;
        if (fin) state_d = ST_RU;
      end
      ST_RU: begin
        jstep = 1'b1; need_rd = 1'b1;
        cmd.rd_a = j_q; cmd.rd_b = j_q - 7'd1;
        cmd.op1 = OP1_SINGLE; cmd.op2 = OP2_R; cmd.w_single = 1'b1; cmd.dest = DST_R;
        if (fin) state_d = ST_V1;
      end
      ST_V1: begin
        jstep = 1'b1; need_rd = 1'b1;
        cmd.rd_a = i_q - 7'd1; cmd.rd_b = j_q;
        cmd.op1 = OP1_P; cmd.op2 = OP2_R; cmd.dest = DST_A;
        if (fin) state_d = ST_V2;
      end
      ST_V2: begin
        jstep = 1'b1; need_rd = 1'b1; need_srd = 1'b1;
        cmd.rd_a = i_q; cmd.rd_b = j_q + 7'd1; cmd.s_rd_addr = j_q + 7'd1;
        cmd.op1 = OP1_A; cmd.op2 = OP2_SMEM; cmd.dest = DST_A;
        if (fin) state_d = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp_en = 1'b1; cmd.cur_i = i_q; cmd.cur_j = j_q;
        if (j_q + 7'd1 < last) begin
          j_d = j_q + 7'd1;
          state_d = swap_q ? ST_MU : ST_RU;
        end else begin
          state_d = ST_PU;
        end
      end
      ST_AP: begin
        if (sts_i.better) begin
          i_d = sts_i.bi;
          j_d = sts_i.bj;
          state_d = ST_A0;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_A0: begin
        cmd.rd_en = 1'b1; cmd.rd_a = i_q; cmd.rd_b = j_q;
        state_d = ST_A1;
      end
      ST_A1: begin
        cmd.wr_en = 1'b1; cmd.wr_addr = i_q; cmd.wr_sel_b = 1'b1;
        state_d = ST_A2;
      end
      ST_A2: begin
        cmd.wr_en = 1'b1; cmd.wr_addr = j_q; cmd.wr_sel_b = 1'b0;
        state_d = ST_A3;
      end
      ST_A3: begin
        if (!swap_q && (i_q + 7'd1 < j_q - 7'd1)) begin
          i_d = i_q + 7'd1;
          j_d = j_q - 7'd1;
          state_d = ST_A0;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_a = (pos_q > POS_W'(MAX_NODES)) ? '0 : pos_q;
        cmd.rd_b = cmd.rd_a;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        cmd.out_read = rdk_q;
        cmd.read_oob = (pos_q > POS_W'(MAX_NODES));
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // three-phase join step: route read, distance read, join
    cmd.rd_en     = cmd.rd_en || (need_rd && (ph_q == 2'd0));
    cmd.s_rd_en   = need_srd && (ph_q == 2'd0);
    cmd.join_en   = jstep && fin;
    cmd.s_wr_en   = cmd.join_en && (state_q == ST_SI || state_q == ST_SS);
    ph_d          = (jstep && !fin) ? ph_q + 2'd1 : 2'd0;
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= '0;
      out_valid_q <= 1'b0;
      ncnt_q      <= POS_W'(MAX_NODES);
      swap_q      <= 1'b0;
      rdk_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
      swap_q      <= swap_d;
      rdk_q       <= rdk_d;
      if (cfg_we_i) begin
        ncnt_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    j_q   <= j_d;
    k_q   <= k_d;
    pos_q <= pos_d;
  end

endmodule

FILE: hw/rtl/min_latency_route_local_search.sv
`timescale 1ns / 1ps
// Top level of the minimum-latency route local search block.
// Depends on mlrls_pkg, mlrls_ctrl and mlrls_dp.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one transaction per request:
//   load distance, load route position, swap pass, reversal pass, read route.
//   Loads finish in the accept cycle and give no result. A read gives one
//   result: the route is read, then the result is loaded once the output
//   register is free. A pass gives one result with the best move, the old
//   and found latencies and whether the move was applied.
//   A pass builds the suffix table, then each candidate is evaluated by a
//   single shared join unit, each join being a route read, a distance read and
//   a join; applying a reversal swaps route entries pair by pair, inward.
//   One request is worked at a time; in_ready_o is high while the controller
//   is idle, also while a finished result waits in the output register.
//   Output channel (out_valid_o / out_ready_i): the result register holds its
//   transaction until taken; a stalled receiver holds the next result back.
//   node_count is written through cfg_we_i / cfg_wdata_i; the user must write
//   it only while idle, as the block does not enforce this.
//   Reset: controller idle, no result pending, node_count = 64; distance,
//   route and internal tables are undefined until written.
module min_latency_route_local_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    req_type_i,
  input  logic [mlrls_pkg::NODE_W-1:0]  from_node_i,
  input  logic [mlrls_pkg::NODE_W-1:0]  to_node_i,
  input  logic [mlrls_pkg::DIST_W-1:0]  distance_i,
  input  logic [mlrls_pkg::POS_W-1:0]   position_i,
  input  logic [mlrls_pkg::NODE_W-1:0]  node_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          applied_o,
  output logic [mlrls_pkg::POS_W-1:0]   move_i_o,
  output logic [mlrls_pkg::POS_W-1:0]   move_j_o,
  output logic [mlrls_pkg::C_W-1:0]     old_latency_o,
  output logic [mlrls_pkg::C_W-1:0]     found_latency_o,
  output logic [mlrls_pkg::NODE_W-1:0]  read_node_o,
  input  logic                          cfg_we_i,
  input  logic [mlrls_pkg::POS_W-1:0]   cfg_wdata_i
);
  import mlrls_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns handshakes, node_count and loop counters
  mlrls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // memories, join unit and result register
  mlrls_dp u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .from_node_i     (from_node_i),
    .to_node_i       (to_node_i),
    .distance_i      (distance_i),
    .position_i      (position_i),
    .node_i          (node_i),
    .applied_o       (applied_o),
    .move_i_o        (move_i_o),
    .move_j_o        (move_j_o),
    .old_latency_o   (old_latency_o),
    .found_latency_o (found_latency_o),
    .read_node_o     (read_node_o)
  );

endmodule
